FILE: rtl/kmsr_pkg.sv
// ----------------------------------------------------------------------------
// kmsr_pkg
// Shared types and constants for the key matrix scanner with crossing remap.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsr_pkg;

	// Fixed field widths
	localparam int ROW_W    = 3;
	localparam int COL_W    = 3;
	localparam int TGT_W    = 5;
	localparam int SLOT_W   = 5;
	localparam int LEVEL_W  = 8;
	localparam int DRIVE_W  = 8;
	localparam int MASK_W   = 32;
	localparam int RCNT_W   = 4;
	localparam int ECNT_W   = 6;
	localparam int SETTLE_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Scan geometry limits
	localparam int MAX_ROWS = 8;
	localparam int MAX_COLS = 8;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd10;
	localparam logic [DRIVE_W-1:0]  DRIVE_IDLE   = '1;

	// Item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE       = 3'd0,
		CFG_ROW_COUNT    = 3'd1,
		CFG_COL_COUNT    = 3'd2,
		CFG_ENTRY_COUNT  = 3'd3,
		CFG_SETTLE_TICKS = 3'd4
	} cfg_index_t;

	// One mapping table entry
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [TGT_W-1:0] target;
	} map_entry_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_FINISH,
		ST_DELIVER
	} kmsr_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic walk;
		logic finish;
		logic deliver;
	} kmsr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sample_due;
		logic walk_done;
		logic out_free;
	} kmsr_status_t;

	// Active-low drive pattern for one row
	function automatic logic [DRIVE_W-1:0] drive_for(input logic [ROW_W-1:0] row);
		drive_for = ~(DRIVE_W'(1) << row);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/kmsr_ctrl.sv
// ----------------------------------------------------------------------------
// kmsr_ctrl
// Sequencer: takes one item, runs its update, walks the mapping table on a
// sample tick, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsr_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire kmsr_pkg::kmsr_status_t status,
	output kmsr_pkg::kmsr_cmd_t   cmd
);

	kmsr_pkg::kmsr_state_t state_q;
	kmsr_pkg::kmsr_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kmsr_pkg::ST_IDLE: begin
				if (in_valid) state_d = kmsr_pkg::ST_EXEC;
			end
			kmsr_pkg::ST_EXEC: begin
				state_d = status.sample_due ? kmsr_pkg::ST_WALK : kmsr_pkg::ST_DELIVER;
			end
			kmsr_pkg::ST_WALK: begin
				if (status.walk_done) state_d = kmsr_pkg::ST_FINISH;
			end
			kmsr_pkg::ST_FINISH: begin
				state_d = kmsr_pkg::ST_DELIVER;
			end
			kmsr_pkg::ST_DELIVER: begin
				if (status.out_free) state_d = kmsr_pkg::ST_IDLE;
			end
			default: begin
				state_d = kmsr_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			kmsr_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			kmsr_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			kmsr_pkg::ST_WALK: begin
				cmd.walk = 1'b1;
			end
			kmsr_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			kmsr_pkg::ST_DELIVER: begin
				cmd.deliver = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/kmsr_datapath.sv
// ----------------------------------------------------------------------------
// kmsr_datapath
// Configuration registers, mapping table memory, scan state, table walk and
// result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsr_datapath #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration
	input  wire                                  cfg_we,
	input  wire [kmsr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [kmsr_pkg::CFG_DATA_W-1:0]       cfg_data,
	// item fields
	input  wire                                  func,
	input  wire [kmsr_pkg::SLOT_W-1:0]           entry_index,
	input  wire [kmsr_pkg::ROW_W-1:0]            entry_row,
	input  wire [kmsr_pkg::COL_W-1:0]            entry_col,
	input  wire [kmsr_pkg::TGT_W-1:0]            entry_target,
	input  wire [kmsr_pkg::LEVEL_W-1:0]          column_levels,
	input  wire [kmsr_pkg::MASK_W-1:0]           base_mask,
	// result channel
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [kmsr_pkg::DRIVE_W-1:0]         row_drive,
	output logic                                 mask_valid,
	output logic [kmsr_pkg::MASK_W-1:0]          pin_mask,
	// control
	input  wire kmsr_pkg::kmsr_cmd_t             cmd,
	output kmsr_pkg::kmsr_status_t               status
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NCW_R = $clog2(MAX_ENTRIES + 1);
	localparam int NCW   = (NCW_R > kmsr_pkg::ECNT_W) ? NCW_R : kmsr_pkg::ECNT_W;

	// Configuration registers
	logic                              enable_q;
	logic [kmsr_pkg::RCNT_W-1:0]       row_count_q;
	logic [kmsr_pkg::RCNT_W-1:0]       col_count_q;
	logic [kmsr_pkg::ECNT_W-1:0]       entry_count_q;
	logic [kmsr_pkg::SETTLE_W-1:0]     settle_ticks_q;

	// Latched item
	logic                              func_q;
	logic [kmsr_pkg::SLOT_W-1:0]       slot_q;
	kmsr_pkg::map_entry_t              load_entry_q;
	logic [kmsr_pkg::LEVEL_W-1:0]      levels_q;
	logic [kmsr_pkg::MASK_W-1:0]       base_q;

	// Scan state
	logic [kmsr_pkg::ROW_W-1:0]        cur_row_q;
	logic [kmsr_pkg::SETTLE_W-1:0]     settle_q;
	logic [kmsr_pkg::MASK_W-1:0]       pressed_q;

	// Walk state
	kmsr_pkg::map_entry_t              map_mem_q [MAX_ENTRIES];
	kmsr_pkg::map_entry_t              rd_q;
	logic                              rd_vld_q;
	logic [NCW-1:0]                    wcnt_q;
	logic [kmsr_pkg::MAX_COLS-1:0]     found_q;
	logic [kmsr_pkg::MASK_W-1:0]       claimed_q;

	// Pending result and output register
	logic [kmsr_pkg::DRIVE_W-1:0]      res_drive_q;
	logic                              res_valid_q;
	logic [kmsr_pkg::MASK_W-1:0]       res_mask_q;
	logic                              out_valid_q;
	logic [kmsr_pkg::DRIVE_W-1:0]      out_drive_q;
	logic                              out_mvalid_q;
	logic [kmsr_pkg::MASK_W-1:0]       out_mask_q;

	// Derived values
	logic [kmsr_pkg::RCNT_W-1:0]       rows_c;
	logic [kmsr_pkg::RCNT_W-1:0]       cols_c;
	logic [NCW-1:0]                    ent_ext;
	logic [NCW-1:0]                    n_c;
	logic                              scan_on;
	logic                              row_ok;
	logic [kmsr_pkg::ROW_W-1:0]        r_eff;
	logic [kmsr_pkg::SETTLE_W-1:0]     settle_new;
	logic [kmsr_pkg::SETTLE_W-1:0]     st_eff;
	logic                              sample_due;
	logic                              load_ok;
	logic                              issue;
	logic                              hit;
	logic [kmsr_pkg::RCNT_W-1:0]       next_row;
	logic                              frame_end;

	// Clamp counts and decide this tick's action
	always_comb begin
		rows_c  = (row_count_q > kmsr_pkg::RCNT_W'(kmsr_pkg::MAX_ROWS)) ?
			kmsr_pkg::RCNT_W'(kmsr_pkg::MAX_ROWS) : row_count_q;
		cols_c  = (col_count_q > kmsr_pkg::RCNT_W'(kmsr_pkg::MAX_COLS)) ?
			kmsr_pkg::RCNT_W'(kmsr_pkg::MAX_COLS) : col_count_q;
		ent_ext = NCW'(entry_count_q);
		n_c     = (ent_ext > NCW'(MAX_ENTRIES)) ? NCW'(MAX_ENTRIES) : ent_ext;
		scan_on = enable_q && (rows_c != '0) && (cols_c != '0) && (n_c != '0);
		row_ok  = {1'b0, cur_row_q} < rows_c;
		r_eff   = row_ok ? cur_row_q : '0;
		settle_new = (row_ok ? settle_q : '0) + 1'b1;
		st_eff  = (settle_ticks_q == '0) ? kmsr_pkg::SETTLE_W'(1) : settle_ticks_q;
		sample_due = (func_q == kmsr_pkg::FUNC_TICK) && scan_on && (settle_new >= st_eff);
		load_ok = 32'(slot_q) < MAX_ENTRIES;
		issue   = cmd.walk && (wcnt_q < n_c);
		hit     = rd_vld_q && (rd_q.row == cur_row_q) && ({1'b0, rd_q.col} < cols_c) &&
			!levels_q[rd_q.col] && !found_q[rd_q.col];
		next_row  = {1'b0, cur_row_q} + 1'b1;
		frame_end = next_row >= rows_c;
	end

	assign status.sample_due = sample_due;
	assign status.walk_done  = (wcnt_q >= n_c) && !rd_vld_q;
	assign status.out_free   = !out_valid_q || out_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			row_count_q    <= '0;
			col_count_q    <= '0;
			entry_count_q  <= '0;
			settle_ticks_q <= kmsr_pkg::SETTLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kmsr_pkg::CFG_ENABLE:       enable_q       <= cfg_data[0];
				kmsr_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_data[kmsr_pkg::RCNT_W-1:0];
				kmsr_pkg::CFG_COL_COUNT:    col_count_q    <= cfg_data[kmsr_pkg::RCNT_W-1:0];
				kmsr_pkg::CFG_ENTRY_COUNT:  entry_count_q  <= cfg_data[kmsr_pkg::ECNT_W-1:0];
				kmsr_pkg::CFG_SETTLE_TICKS: settle_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q              <= func;
			slot_q              <= entry_index;
			load_entry_q.row    <= entry_row;
			load_entry_q.col    <= entry_col;
			load_entry_q.target <= entry_target;
			levels_q            <= column_levels;
			base_q              <= base_mask;
		end
	end

	// Mapping table: write on load, registered read during the walk
	always_ff @(posedge clk) begin
		if (cmd.exec && (func_q == kmsr_pkg::FUNC_LOAD) && load_ok) begin
			map_mem_q[IDX_W'(slot_q)] <= load_entry_q;
		end
		if (issue) begin
			rd_q <= map_mem_q[wcnt_q[IDX_W-1:0]];
		end
	end

	// Walk pointer and read pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q   <= '0;
			rd_vld_q <= 1'b0;
		end else if (cmd.exec) begin
			wcnt_q   <= '0;
			rd_vld_q <= 1'b0;
		end else if (cmd.walk) begin
			rd_vld_q <= issue;
			if (issue) wcnt_q <= wcnt_q + 1'b1;
		end
	end

	// Per-walk column hits and claimed targets
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			found_q   <= '0;
			claimed_q <= '0;
		end else if (cmd.walk && rd_vld_q) begin
			claimed_q[rd_q.target] <= 1'b1;
			if (hit) found_q[rd_q.col] <= 1'b1;
		end
	end

	// Scan state: row, settle counter, pressed bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			settle_q  <= '0;
			pressed_q <= '0;
		end else if (cmd.exec && (func_q == kmsr_pkg::FUNC_TICK)) begin
			if (!scan_on) begin
				cur_row_q <= '0;
				settle_q  <= '0;
				pressed_q <= '0;
			end else begin
				cur_row_q <= r_eff;
				settle_q  <= sample_due ? '0 : settle_new;
			end
		end else if (cmd.walk && hit) begin
			pressed_q[rd_q.target] <= 1'b1;
		end else if (cmd.finish) begin
			settle_q <= '0;
			if (frame_end) begin
				cur_row_q <= '0;
				pressed_q <= '0;
			end else begin
				cur_row_q <= next_row[kmsr_pkg::ROW_W-1:0];
			end
		end
	end

	// Form the pending result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_valid_q <= 1'b0;
			res_mask_q  <= '0;
			if (func_q == kmsr_pkg::FUNC_LOAD) begin
				res_drive_q <= (scan_on && row_ok) ?
					kmsr_pkg::drive_for(cur_row_q) : kmsr_pkg::DRIVE_IDLE;
			end else if (!scan_on) begin
				res_drive_q <= kmsr_pkg::DRIVE_IDLE;
				res_valid_q <= 1'b1;
				res_mask_q  <= base_q;
			end else begin
				res_drive_q <= kmsr_pkg::drive_for(r_eff);
			end
		end else if (cmd.finish) begin
			res_drive_q <= kmsr_pkg::drive_for(cur_row_q);
			res_valid_q <= frame_end;
			res_mask_q  <= frame_end ? ((base_q & ~claimed_q) | pressed_q) : '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			out_drive_q  <= res_drive_q;
			out_mvalid_q <= res_valid_q;
			out_mask_q   <= res_mask_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_drive  = out_drive_q;
	assign mask_valid = out_mvalid_q;
	assign pin_mask   = out_mask_q;

endmodule

`default_nettype wire

FILE: rtl/key_matrix_scan_remap_core.sv
// ----------------------------------------------------------------------------
// key_matrix_scan_remap_core
// Button matrix scanner: drives rows one at a time, samples the columns after
// the settle time, remaps pressed crossings through a loaded table and merges
// the result into the incoming pin mask at the end of each frame.
//
//   Channel   Direction  Handshake               Payload
//   cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//   in        in         in_valid / in_ready     func, entry_*, column_levels,
//                                                base_mask
//   out       out        out_valid / out_ready   row_drive, mask_valid, pin_mask
//
// A load item or a tick without sampling passes the execute and delivery steps:
// the result enters the output register as the block returns to idle. A
// sampling tick walks the mapping table through its single read port, one
// entry per cycle up to entry_count (clamped to MAX_ENTRIES), then passes the
// finish and delivery steps.
// An item is taken while the previous result still waits in the output
// register; a stalled output holds the block in its delivery step.
// Reset clears configuration (settle time 10), scan state and all handshakes;
// mapping table contents stay undefined until loaded. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_scan_remap_core #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [kmsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [kmsr_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              func,
	input  wire [kmsr_pkg::SLOT_W-1:0]       entry_index,
	input  wire [kmsr_pkg::ROW_W-1:0]        entry_row,
	input  wire [kmsr_pkg::COL_W-1:0]        entry_col,
	input  wire [kmsr_pkg::TGT_W-1:0]        entry_target,
	input  wire [kmsr_pkg::LEVEL_W-1:0]      column_levels,
	input  wire [kmsr_pkg::MASK_W-1:0]       base_mask,
	// results
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [kmsr_pkg::DRIVE_W-1:0]     row_drive,
	output logic                             mask_valid,
	output logic [kmsr_pkg::MASK_W-1:0]      pin_mask
);

	kmsr_pkg::kmsr_cmd_t    cmd;
	kmsr_pkg::kmsr_status_t status;

	assign cfg_ready = 1'b1;

	// Sequencer
	kmsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath
	kmsr_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.entry_index   (entry_index),
		.entry_row     (entry_row),
		.entry_col     (entry_col),
		.entry_target  (entry_target),
		.column_levels (column_levels),
		.base_mask     (base_mask),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.row_drive     (row_drive),
		.mask_valid    (mask_valid),
		.pin_mask      (pin_mask),
		.cmd           (cmd),
		.status        (status)
	);

	// One item at a time: a transfer closes the input until its result is out
	a_busy_after_transfer : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input taken again right after a transfer");

	// A new result only follows a busy cycle
	a_result_from_work : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
	else $error("result appeared without an item in work");

	// Results without a finished frame carry an empty mask
	a_empty_mask : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mask_valid |-> pin_mask == '0)
	else $error("pin_mask set while mask_valid is low");

endmodule

`default_nettype wire
